>>> hw/rtl/hpid_pkg.sv
// Package for the heading PID regulator: field widths, register indexes,
// reset values and the struct types passed between the submodules.
// No dependencies.
`default_nettype none

package hpid_pkg;

    // Field and register widths.
    localparam int AngleW = 16;
    localparam int GainW  = 24;
    localparam int BoundW = 15;
    localparam int RateW  = 16;
    localparam int SumW   = 32;
    localparam int CfgAddrW = 3;
    localparam int CfgDataW = GainW;

    // Widths of the intermediate terms and products.
    localparam int IntegW = SumW + 1;            // error plus running sum
    localparam int DiffW  = AngleW + 1;          // error minus last error
    localparam int PropPW = GainW + 1 + AngleW;  // products with a zero-extended gain
    localparam int IntegPW = GainW + 1 + IntegW;
    localparam int DiffPW = GainW + 1 + DiffW;
    localparam int AccW   = IntegPW + 1;         // sum of the three products
    localparam int FracSh = 16;                  // drive scaling shift
    localparam int FullW  = AccW - FracSh;       // drive after the shift

    // Configuration register indexes.
    localparam logic [CfgAddrW-1:0] RegTarget    = 3'd0;
    localparam logic [CfgAddrW-1:0] RegGainProp  = 3'd1;
    localparam logic [CfgAddrW-1:0] RegGainInteg = 3'd2;
    localparam logic [CfgAddrW-1:0] RegGainDeriv = 3'd3;
    localparam logic [CfgAddrW-1:0] RegMaxRate   = 3'd4;

    // Configuration reset values.
    localparam logic [AngleW-1:0] TargetRst    = 16'd0;
    localparam logic [GainW-1:0]  GainPropRst  = 24'd257359;
    localparam logic [GainW-1:0]  GainIntegRst = 24'd26;
    localparam logic [GainW-1:0]  GainDerivRst = 24'd25736;
    localparam logic [BoundW-1:0] MaxRateRst   = 15'd9324;

    // Error terms handed from the error stage to the drive logic.
    typedef struct packed {
        logic signed [AngleW-1:0] err;
        logic signed [IntegW-1:0] integ;
        logic signed [DiffW-1:0]  diff;
    } t_err_terms;

    // Clamped drive handed to the result register.
    typedef struct packed {
        logic signed [RateW-1:0] rate;
        logic                    clamped;
    } t_drive;

    // Gains and bound used by the drive logic.
    typedef struct packed {
        logic [GainW-1:0]  gain_prop;
        logic [GainW-1:0]  gain_integ;
        logic [GainW-1:0]  gain_deriv;
        logic [BoundW-1:0] max_rate;
    } t_gains;

endpackage

`default_nettype wire

>>> hw/rtl/heading_pid_regulator.sv
// Heading PID regulator, top level: configuration registers, input register,
// result register and the valid/ready control between them.
// A transaction passes the input register, then the result register.
// Throughput: one transaction per cycle while i_ready is high, set by the
// single compute stage between the input register and the result register.
// Reset clears both stages, the last error and the error sum, and loads the
// default target, gains and rate bound.
`default_nettype none

module heading_pid_regulator
    import hpid_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration write port.
    input  wire logic                i_cfg_we,
    input  wire logic [CfgAddrW-1:0] i_cfg_addr,
    input  wire logic [CfgDataW-1:0] i_cfg_wdata,
    // Input channel.
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [AngleW-1:0]   i_heading,
    // Result channel.
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic signed [RateW-1:0]  o_angular_rate,
    output logic                     o_clamped
);

    logic [AngleW-1:0] r_target;
    t_gains            r_gains;
    logic              r_in_valid;
    logic [AngleW-1:0] r_heading;
    logic              r_out_valid;
    t_drive            r_result;
    logic              out_free;
    logic              advance;
    t_err_terms        terms;
    t_drive            drive;

    // Configuration register writes; unknown indexes are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target           <= TargetRst;
            r_gains.gain_prop  <= GainPropRst;
            r_gains.gain_integ <= GainIntegRst;
            r_gains.gain_deriv <= GainDerivRst;
            r_gains.max_rate   <= MaxRateRst;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegTarget:    r_target           <= i_cfg_wdata[AngleW-1:0];
                RegGainProp:  r_gains.gain_prop  <= i_cfg_wdata[GainW-1:0];
                RegGainInteg: r_gains.gain_integ <= i_cfg_wdata[GainW-1:0];
                RegGainDeriv: r_gains.gain_deriv <= i_cfg_wdata[GainW-1:0];
                RegMaxRate:   r_gains.max_rate   <= i_cfg_wdata[BoundW-1:0];
                default: ;
            endcase
        end
    end

    // Handshake: the input stage moves on whenever the result register is free.
    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && out_free;
    assign o_ready  = !r_in_valid || out_free;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_heading <= i_heading;
        end
    end

    hpid_error u_error (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_target  (r_target),
        .i_heading (r_heading),
        .i_update  (advance),
        .o_terms   (terms)
    );

    hpid_drive u_drive (
        .i_terms (terms),
        .i_gains (r_gains),
        .o_drive (drive)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= drive;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_angular_rate = r_result.rate;
    assign o_clamped      = r_result.clamped;

endmodule

`default_nettype wire

>>> hw/rtl/hpid_error.sv
// Heading error stage: wraps target minus heading to a signed angle, forms
// the integral and derivative terms and holds the last error and error sum.
// Depends on hpid_pkg.
`default_nettype none

module hpid_error
    import hpid_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [AngleW-1:0] i_target,
    input  wire logic [AngleW-1:0] i_heading,
    input  wire logic              i_update,
    output t_err_terms             o_terms
);

    function automatic logic sum_ext_sign(input logic signed [SumW-1:0] val);
        return val[SumW-1];
    endfunction

    logic signed [AngleW-1:0] r_last_error;
    logic signed [AngleW-1:0] n_last_error;
    logic signed [SumW-1:0]   r_error_sum;
    logic signed [SumW-1:0]   n_error_sum;
    logic signed [AngleW-1:0] err;
    logic signed [IntegW-1:0] sum_ext;

    // The modulo 2^16 difference is already the wrapped signed angle.
    assign err = $signed(i_target - i_heading);

    // Integral and derivative terms at full width.
    assign sum_ext = {sum_ext_sign(r_error_sum), r_error_sum};
    assign o_terms.err   = err;
    assign o_terms.integ = sum_ext + IntegW'(err);
    assign o_terms.diff  = DiffW'(err) - DiffW'(r_last_error);

    // The running sum saturates at the 32-bit signed limits.
    always_comb begin
        n_last_error = err;
        if (o_terms.integ[IntegW-1] != o_terms.integ[IntegW-2]) begin
            n_error_sum = o_terms.integ[IntegW-1] ? {1'b1, {(SumW-1){1'b0}}}
                                                   : {1'b0, {(SumW-1){1'b1}}};
        end else begin
            n_error_sum = o_terms.integ[SumW-1:0];
        end
    end

    // State advances once for each transaction that reaches the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_error <= '0;
            r_error_sum  <= '0;
        end else if (i_update) begin
            r_last_error <= n_last_error;
            r_error_sum  <= n_error_sum;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/hpid_drive.sv
// Drive computation: three gain products, negation, floor shift by 16 and
// the symmetric clamp to the rate bound.
// Depends on hpid_pkg.
`default_nettype none

module hpid_drive
    import hpid_pkg::*;
(
    input  wire t_err_terms i_terms,
    input  wire t_gains     i_gains,
    output t_drive          o_drive
);

    logic signed [PropPW-1:0]  p_prop;
    logic signed [IntegPW-1:0] p_integ;
    logic signed [DiffPW-1:0]  p_deriv;
    logic signed [AccW-1:0]    acc;
    logic signed [AccW-1:0]    neg_acc;
    logic signed [FullW-1:0]   rate_full;
    logic signed [FullW-1:0]   bound;

    // Gains are unsigned, so they enter the products with a zero sign bit.
    assign p_prop  = $signed({1'b0, i_gains.gain_prop})  * $signed(i_terms.err);
    assign p_integ = $signed({1'b0, i_gains.gain_integ}) * $signed(i_terms.integ);
    assign p_deriv = $signed({1'b0, i_gains.gain_deriv}) * $signed(i_terms.diff);

    assign acc = AccW'(p_prop) + AccW'(p_integ) + AccW'(p_deriv);

    // Negated drive; the upper bits are the floor of the shift by 16.
    assign neg_acc   = -acc;
    assign rate_full = neg_acc[AccW-1:FracSh];
    assign bound     = $signed(FullW'(i_gains.max_rate));

    // Clamp to plus or minus the bound; a drive equal to it passes.
    always_comb begin
        if (rate_full > bound) begin
            o_drive.rate    = $signed(RateW'(i_gains.max_rate));
            o_drive.clamped = 1'b1;
        end else if (rate_full < -bound) begin
            o_drive.rate    = -$signed(RateW'(i_gains.max_rate));
            o_drive.clamped = 1'b1;
        end else begin
            o_drive.rate    = rate_full[RateW-1:0];
            o_drive.clamped = 1'b0;
        end
    end

endmodule

`default_nettype wire
